FILE: src/cmm_pkg.sv
// Shared types and constants for the complex matrix multiply unit.
package cmm_pkg;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_LOAD_C  = 2'd2,
        OP_COMPUTE = 2'd3
    } op_t;

    localparam int REG_ROWS_M   = 0;
    localparam int REG_COLS_N   = 1;
    localparam int REG_INNER_K  = 2;
    localparam int REG_ALPHA_RE = 3;
    localparam int REG_ALPHA_IM = 4;
    localparam int REG_ADD_MODE = 5;
    localparam int REG_CONJ_A   = 6;
    localparam int REG_CONJ_B   = 7;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int ELEM_BITS     = 16;
    localparam int RES_BITS      = 56;
    localparam int ACC_BITS      = 40;

    // queue entry between front and back
    typedef struct packed {
        op_t         op;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [15:0] value_re;
        logic [15:0] value_im;
    } cmd_t;

endpackage

FILE: src/cmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: src/cmm_queue.sv
// Two-entry command queue between the front and back parts.
module cmm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  cmm_pkg::cmd_t   in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output cmm_pkg::cmd_t   out_cmd
);
    import cmm_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (out_valid && out_ready)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end
endmodule

FILE: src/cmm_engine.sv
// Back part: element stores, load writes and the multiply-accumulate sequencer.
module cmm_engine #(
    parameter int MAX_DIM   = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  cmm_pkg::cmd_t                 cmd,
    input  logic [3:0]                    rows_m,
    input  logic [3:0]                    cols_n,
    input  logic [3:0]                    inner_k,
    input  logic signed [15:0]            alpha_re,
    input  logic signed [15:0]            alpha_im,
    input  logic                          add_mode,
    input  logic                          conj_a,
    input  logic                          conj_b,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [2:0]                    out_row,
    output logic [2:0]                    out_col,
    output logic signed [cmm_pkg::RES_BITS-1:0] result_re,
    output logic signed [cmm_pkg::RES_BITS-1:0] result_im,
    output logic                          last
);
    import cmm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int EW    = 2 * ELEM_BITS;
    localparam int PW    = 2 * ELEM_BITS + 2;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_MUL, S_ACC, S_SCALE, S_SUM, S_OUT
    } state_t;

    state_t state_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic [IW-1:0] m_max, n_max, k_max;
    logic signed [ACC_BITS-1:0] sr_reg, si_reg;
    logic signed [PW-1:0] pr_reg, pi_reg;
    logic signed [RES_BITS-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [RES_BITS-1:0] rre_reg, rim_reg;
    logic last_reg;

    function automatic logic [IW-1:0] clamp_dim(input logic [3:0] d);
        logic [IW-1:0] r;
        if (d == 4'd0)
            r = '0;
        else if (32'(d) > MAX_DIM)
            r = IW'(MAX_DIM - 1);
        else
            r = IW'(d - 4'd1);
        return r;
    endfunction

    assign m_max = clamp_dim(rows_m);
    assign n_max = clamp_dim(cols_n);
    assign k_max = clamp_dim(inner_k);

    // store writes
    logic          ld;
    logic [AW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic          in_range;
    assign in_range = (32'(cmd.row) < MAX_DIM) && (32'(cmd.col) < MAX_DIM);
    assign ld    = cmd_valid && cmd_ready && (cmd.op != OP_COMPUTE) && in_range;
    assign waddr = AW'(32'(cmd.row) * MAX_DIM + 32'(cmd.col));
    assign wdata = {cmd.value_re[ELEM_BITS-1:0], cmd.value_im[ELEM_BITS-1:0]};

    logic [AW-1:0] a_ra, b_ra, c_ra;
    logic [EW-1:0] a_rd, b_rd, c_rd;
    assign a_ra = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
    assign b_ra = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));
    assign c_ra = AW'(32'(i_reg) * MAX_DIM + 32'(j_reg));

    cmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_a (.clk(clk), .we(ld && cmd.op == OP_LOAD_A),
        .waddr(waddr), .wdata(wdata), .raddr(a_ra), .rdata(a_rd));
    cmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_b (.clk(clk), .we(ld && cmd.op == OP_LOAD_B),
        .waddr(waddr), .wdata(wdata), .raddr(b_ra), .rdata(b_rd));
    cmm_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_c (.clk(clk), .we(ld && cmd.op == OP_LOAD_C),
        .waddr(waddr), .wdata(wdata), .raddr(c_ra), .rdata(c_rd));

    logic signed [ELEM_BITS:0] ar, ai, br, bi;
    always_comb
    begin
        ar = (ELEM_BITS+1)'($signed(a_rd[EW-1:ELEM_BITS]));
        ai = (ELEM_BITS+1)'($signed(a_rd[ELEM_BITS-1:0]));
        br = (ELEM_BITS+1)'($signed(b_rd[EW-1:ELEM_BITS]));
        bi = (ELEM_BITS+1)'($signed(b_rd[ELEM_BITS-1:0]));
        if (conj_a) ai = -ai;
        if (conj_b) bi = -bi;
    end

    logic signed [RES_BITS-1:0] c_re, c_im;
    assign c_re = RES_BITS'($signed(c_rd[EW-1:ELEM_BITS]));
    assign c_im = RES_BITS'($signed(c_rd[ELEM_BITS-1:0]));

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_OUT);
    assign out_row   = 3'(i_reg);
    assign out_col   = 3'(j_reg);
    assign result_re = rre_reg;
    assign result_im = rim_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd.op == OP_COMPUTE)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        k_reg     <= '0;
                        sr_reg    <= '0;
                        si_reg    <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    pr_reg    <= PW'(ar * br) - PW'(ai * bi);
                    pi_reg    <= PW'(ar * bi) + PW'(ai * br);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    sr_reg <= sr_reg + ACC_BITS'(pr_reg);
                    si_reg <= si_reg + ACC_BITS'(pi_reg);
                    if (k_reg == k_max)
                    begin
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_SCALE:
                begin
                    t1_reg    <= RES_BITS'(alpha_re * sr_reg);
                    t2_reg    <= RES_BITS'(alpha_im * si_reg);
                    t3_reg    <= RES_BITS'(alpha_re * si_reg);
                    t4_reg    <= RES_BITS'(alpha_im * sr_reg);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    rre_reg   <= t1_reg - t2_reg + (add_mode ? c_re : '0);
                    rim_reg   <= t3_reg + t4_reg + (add_mode ? c_im : '0);
                    last_reg  <= (i_reg == m_max) && (j_reg == n_max);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (res_ready)
                    begin
                        sr_reg <= '0;
                        si_reg <= '0;
                        k_reg  <= '0;
                        if (last_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if (i_reg == m_max)
                            begin
                                i_reg <= '0;
                                j_reg <= j_reg + 1'b1;
                            end
                            else
                            begin
                                i_reg <= i_reg + 1'b1;
                            end
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: src/complex_matrix_multiply_unit.sv
// Complex matrix multiply unit: top level with front end, queue and engine.
// Flow: a load waits in a queue slot and is written to its store once the engine is idle;
// a compute item reads, multiplies and accumulates per inner index, then scales and sums.
// Throughput: loads 1 per cycle while the engine is idle; a result element waits in the
// output state until out_ready, and the engine takes no new item until it is idle again.
// Reset: asynchronous active low; control registers reset, data regs and stores do not.
module complex_matrix_multiply_unit #(
    parameter int MAX_DIM   = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cmm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [cmm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            op,
    input  logic [2:0]                            row,
    input  logic [2:0]                            col,
    input  logic signed [15:0]                    value_re,
    input  logic signed [15:0]                    value_im,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [2:0]                            out_row,
    output logic [2:0]                            out_col,
    output logic signed [cmm_pkg::RES_BITS-1:0]   result_re,
    output logic signed [cmm_pkg::RES_BITS-1:0]   result_im,
    output logic                                  last
);
    import cmm_pkg::*;

    // configuration registers
    logic [3:0]         rows_m_reg, cols_n_reg, inner_k_reg;
    logic signed [15:0] alpha_re_reg, alpha_im_reg;
    logic               add_mode_reg, conj_a_reg, conj_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg   <= 4'd8;
            cols_n_reg   <= 4'd8;
            inner_k_reg  <= 4'd8;
            alpha_re_reg <= 16'sd1;
            alpha_im_reg <= 16'sd0;
            add_mode_reg <= 1'b0;
            conj_a_reg   <= 1'b0;
            conj_b_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (32'(cfg_index))
                REG_ROWS_M:   rows_m_reg   <= cfg_data[3:0];
                REG_COLS_N:   cols_n_reg   <= cfg_data[3:0];
                REG_INNER_K:  inner_k_reg  <= cfg_data[3:0];
                REG_ALPHA_RE: alpha_re_reg <= cfg_data;
                REG_ALPHA_IM: alpha_im_reg <= cfg_data;
                REG_ADD_MODE: add_mode_reg <= cfg_data[0];
                REG_CONJ_A:   conj_a_reg   <= cfg_data[0];
                REG_CONJ_B:   conj_b_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // front: pack the item into a command and push it to the queue
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    always_comb
    begin
        in_cmd.op       = op_t'(op);
        in_cmd.row      = row;
        in_cmd.col      = col;
        in_cmd.value_re = value_re;
        in_cmd.value_im = value_im;
    end

    cmm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    // back: stores and the multiply sequencer
    cmm_engine #(.MAX_DIM(MAX_DIM)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .rows_m(rows_m_reg), .cols_n(cols_n_reg), .inner_k(inner_k_reg),
        .alpha_re(alpha_re_reg), .alpha_im(alpha_im_reg),
        .add_mode(add_mode_reg), .conj_a(conj_a_reg), .conj_b(conj_b_reg),
        .res_valid(out_valid), .res_ready(out_ready),
        .out_row(out_row), .out_col(out_col),
        .result_re(result_re), .result_im(result_im), .last(last)
    );

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_re) && $stable(last))
        else $error("result changed while stalled");

    // last only on the final row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> out_row == 3'(rows_m_reg == 4'd0 ? 4'd0 :
            (rows_m_reg > 4'(MAX_DIM) ? 4'(MAX_DIM - 1) : rows_m_reg - 4'd1)))
        else $error("last on wrong row");

    // after an accepted result that is not last, out_valid drops before the next result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> !out_valid ##1 1'b1)
        else $error("results without gap");

endmodule
